>>> hdl/sstsrch_pkg.sv
`default_nettype none

package sstsrch_pkg;

   // Fixed field widths of the transaction payloads and the register.
   localparam int SLOT_W  = 10;
   localparam int KEY_IN_W = 32;
   localparam int COUNT_W = 11;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [SLOT_W-1:0]   slot_index;
      logic                slot_empty;
      logic [KEY_IN_W-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic res_valid;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MID,
      ST_RSCAN,
      ST_LSCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hdl/sparse_sorted_table_search_core.sv
`default_nettype none

// Channel   Direction  Handshake          Carries
// req_*     in         valid / stall      one load or search transaction
// rsp_*     out        valid / stall      found flag and position of a search
// csr_*     in         valid / ready      entry_count register write data
//
// A load transaction is written into the table memory at the edge that accepts it; it
// produces no response. A search starts in the idle state; each probe forms the midpoint
// and reads one slot through the single memory read port, scans past empty slots read
// one further slot each, and the finished result is then handed to the response register.
// Reset clears the control state and entry_count only; the table itself is not cleared.
// req_stall is high while a search is in progress, including while its result waits for
// the response register; a held response does not block the next request transaction.

module sparse_sorted_table_search_core #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire sstsrch_pkg::req_type                 req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output sstsrch_pkg::rsp_type                      rsp_payload,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sstsrch_pkg::COUNT_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   logic [sstsrch_pkg::COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sstsrch_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;

   sstsrch_pkg::status_type status;
   sstsrch_pkg::rsp_type    result;
   logic                    start;
   logic                    res_take;
   logic [31:0]             count_wide;
   logic [CNT_W-1:0]        count_sat;

   // The register is always writable; software must write it only while the core is idle; the core does not check this.
   assign csr_ready = 1'b1;

   always_comb begin
      entry_count_in = entry_count_ff;
      if (csr_valid && csr_ready) begin
         entry_count_in = csr_wdata;
      end
   end

   // A count beyond the table depth searches the whole table.
   assign count_wide = 32'(entry_count_ff);
   always_comb begin
      if (count_wide > 32'(TABLE_DEPTH)) begin
         count_sat = CNT_W'(TABLE_DEPTH);
      end else begin
         count_sat = count_wide[CNT_W-1:0];
      end
   end

   assign req_stall = status.busy;
   assign start     = req_valid && !req_stall;

   sstsrch_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (req_payload),
      .count    (count_sat),
      .res_take (res_take),
      .status   (status),
      .result   (result)
   );

   // The response register takes a finished result when it is empty or being drained.
   assign res_take = status.res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

>>> hdl/sstsrch_engine.sv
`default_nettype none

module sstsrch_engine #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire sstsrch_pkg::req_type              item,
   input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]  count,
   input  wire logic                              res_take,
   output sstsrch_pkg::status_type                status,
   output sstsrch_pkg::rsp_type                   result
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   // Each word holds the empty mark above the key.
   logic [KEY_WIDTH:0] mem [TABLE_DEPTH];

   sstsrch_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     low_ff, low_in;
   logic [CNT_W-1:0]     hp_ff, hp_in;
   logic [CNT_W-1:0]     mid_ff, mid_in;
   logic [CNT_W-1:0]     probe_ff, probe_in;
   logic [KEY_WIDTH-1:0] target_ff, target_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [KEY_WIDTH:0]   rd_data_ff;

   logic                 rd_en;
   logic [CNT_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [31:0]          slot_wide;
   logic [63:0]          key_wide;
   logic [KEY_WIDTH-1:0] item_key;
   logic [CNT_W-1:0]     mid_calc;
   logic [CNT_W-1:0]     probe_inc;
   logic [CNT_W-1:0]     probe_dec;
   logic [KEY_WIDTH-1:0] rd_key;
   logic                 rd_empty;
   logic [31:0]          pos_wide;

   assign slot_wide = 32'(item.slot_index);
   assign key_wide  = 64'(item.key_value);
   assign item_key  = key_wide[KEY_WIDTH-1:0];
   assign wr_en     = start && (item.mode == sstsrch_pkg::MODE_LOAD)
                      && (slot_wide < 32'(TABLE_DEPTH));
   assign wr_addr   = slot_wide[IDX_W-1:0];

   assign mid_calc  = low_ff + ((hp_ff - low_ff - CNT_W'(1)) >> 1);
   assign probe_inc = probe_ff + CNT_W'(1);
   assign probe_dec = probe_ff - CNT_W'(1);
   assign rd_key    = rd_data_ff[KEY_WIDTH-1:0];
   assign rd_empty  = rd_data_ff[KEY_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {item.slot_empty, item_key};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sstsrch_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      low_ff    <= low_in;
      hp_ff     <= hp_in;
      mid_ff    <= mid_in;
      probe_ff  <= probe_in;
      target_ff <= target_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
   end

   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      hp_in     = hp_ff;
      mid_in    = mid_ff;
      probe_in  = probe_ff;
      target_in = target_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      rd_en     = 1'b0;
      rd_addr   = probe_ff;

      case (state_ff)
         sstsrch_pkg::ST_IDLE: begin
            if (start && (item.mode == sstsrch_pkg::MODE_SEARCH)) begin
               low_in    = '0;
               hp_in     = count;
               target_in = item_key;
               state_in  = sstsrch_pkg::ST_MID;
            end
         end
         sstsrch_pkg::ST_MID: begin
            if (low_ff >= hp_ff) begin
               found_in = 1'b0;
               state_in = sstsrch_pkg::ST_DONE;
            end else begin
               mid_in   = mid_calc;
               probe_in = mid_calc;
               rd_en    = 1'b1;
               rd_addr  = mid_calc;
               state_in = sstsrch_pkg::ST_RSCAN;
            end
         end
         sstsrch_pkg::ST_RSCAN, sstsrch_pkg::ST_LSCAN: begin
            if (!rd_empty) begin
               if (rd_key < target_ff) begin
                  low_in   = probe_inc;
                  state_in = sstsrch_pkg::ST_MID;
               end else if (rd_key > target_ff) begin
                  hp_in    = mid_ff;
                  state_in = sstsrch_pkg::ST_MID;
               end else begin
                  found_in = 1'b1;
                  pos_in   = probe_ff;
                  state_in = sstsrch_pkg::ST_DONE;
               end
            end else if (state_ff == sstsrch_pkg::ST_RSCAN) begin
               if (probe_inc < hp_ff) begin
                  probe_in = probe_inc;
                  rd_en    = 1'b1;
                  rd_addr  = probe_inc;
               end else if (mid_ff == low_ff) begin
                  found_in = 1'b0;
                  state_in = sstsrch_pkg::ST_DONE;
               end else begin
                  // The right side is all empty; the left scan starts just below mid.
                  probe_in = mid_ff - CNT_W'(1);
                  rd_en    = 1'b1;
                  rd_addr  = mid_ff - CNT_W'(1);
                  state_in = sstsrch_pkg::ST_LSCAN;
               end
            end else begin
               if (probe_ff == low_ff) begin
                  found_in = 1'b0;
                  state_in = sstsrch_pkg::ST_DONE;
               end else begin
                  probe_in = probe_dec;
                  rd_en    = 1'b1;
                  rd_addr  = probe_dec;
               end
            end
         end
         sstsrch_pkg::ST_DONE: begin
            if (res_take) begin
               state_in = sstsrch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sstsrch_pkg::ST_IDLE;
         end
      endcase
   end

   assign pos_wide         = 32'(pos_ff);
   assign status.busy      = (state_ff != sstsrch_pkg::ST_IDLE);
   assign status.res_valid = (state_ff == sstsrch_pkg::ST_DONE);
   assign result.found     = found_ff;
   assign result.position  = found_ff ? pos_wide[sstsrch_pkg::SLOT_W-1:0]
                                      : '0;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps

// Testbench for the sparse sorted table search core.
//
// Load transactions fill table slots and search transactions look up a key.
// Every accepted search that the directed table does not pin is run through a
// predictor that repeats the same probing binary search on a private copy of the
// table. Responses are then compared field by field, oldest first.
module tb;
   import sstsrch_pkg::*;

   localparam int DEPTH      = 1024;
   localparam int MAX_GAP    = 6;
   // A load takes one cycle, so a short pause covers it before a register write.
   localparam int SETTLE_CYC = 8;
   // This is the quiet time at the end.
   localparam int DRAIN_CYC  = 64;
   // The receiver holds off this long so that the core backs up into its input.
   localparam int HOLD_CYC   = 250;

   typedef enum logic {ROW_COUNT, ROW_ITEM} row_kind_t;

   typedef struct {
      row_kind_t          kind;
      logic [COUNT_W-1:0] count;
      req_type            item;
      bit                 pinned;
      rsp_type            want;
   } row_t;

   // One note travels with each search transaction. It says whether the directed
   // table typed in the answer, or whether the predictor has to work it out.
   typedef struct {
      bit      pinned;
      rsp_type want;
   } search_note_t;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_valid   = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_wdata   = '0;

   sparse_sorted_table_search_core #(
      .TABLE_DEPTH(DEPTH),
      .KEY_WIDTH  (32)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // This is the predictor's own copy of the table and of the entry count.
   logic [KEY_IN_W-1:0] shadow_key [DEPTH];
   bit                  shadow_gap [DEPTH];
   int unsigned         shadow_count = 0;

   rsp_type             lookup_expect_q [$];
   search_note_t        search_note_q [$];
   int                  mismatches = 0;

   // This is the stimulus side's view of what it loaded. It is used only to choose
   // search keys and loads, so it never has to follow the core cycle by cycle.
   logic [KEY_IN_W-1:0] layout_key [DEPTH];
   bit                  layout_gap [DEPTH];
   int                  layout_count = 0;
   bit                  burst = 1'b0;

   row_t                directed_rows [$];

   // This is the probing binary search. At each probe it walks right from the
   // midpoint past empty slots. If the walk runs off the upper bound, it walks left
   // instead. If both walks find only empty slots, the key is not present.
   function automatic rsp_type locate_key(input logic [KEY_IN_W-1:0] target);
      int      lo;
      int      hi;
      int      mid;
      int      probe;
      rsp_type hit;
      hit = '0;
      lo  = 0;
      hi  = ((shadow_count > DEPTH) ? DEPTH : int'(shadow_count)) - 1;
      while (lo <= hi) begin
         mid   = lo + (hi - lo) / 2;
         probe = mid;
         while (probe <= hi && shadow_gap[probe])
            probe++;
         if (probe > hi) begin
            probe = mid;
            while (probe >= lo && shadow_gap[probe])
               probe--;
            if (probe < lo)
               return hit;
         end
         if (shadow_key[probe] < target) begin
            lo = probe + 1;
         end else if (shadow_key[probe] > target) begin
            hi = mid - 1;
         end else begin
            hit.found    = 1'b1;
            hit.position = probe[SLOT_W-1:0];
            return hit;
         end
      end
      return hit;
   endfunction

   // The monitor samples every handshake at the clock edge. It updates the shadow
   // state for loads and register writes, queues an expectation for each accepted
   // search, and checks each accepted response against the oldest expectation.
   always @(posedge clock) begin : watch
      search_note_t note;
      rsp_type      want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            shadow_count = csr_wdata;
         if (req_valid && !req_stall) begin
            if (req_payload.mode == MODE_LOAD) begin
               shadow_key[req_payload.slot_index] = req_payload.key_value;
               shadow_gap[req_payload.slot_index] = req_payload.slot_empty;
            end else begin
               note = search_note_q.pop_front();
               lookup_expect_q.push_back(note.pinned ? note.want
                                                     : locate_key(req_payload.key_value));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (lookup_expect_q.size() == 0) begin
               $error("response with no search outstanding: found %0d position %0d",
                      rsp_payload.found, rsp_payload.position);
               mismatches++;
            end else begin
               want = lookup_expect_q.pop_front();
               if (rsp_payload.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_payload.found);
                  mismatches++;
               end
               if (rsp_payload.position !== want.position) begin
                  $error("position: expected %0d, actual %0d",
                         want.position, rsp_payload.position);
                  mismatches++;
               end
            end
         end
      end
   end

   // The receiver waits a random number of cycles before it takes each response.
   // When it has taken 40 or 400 responses it holds off for a long stretch. During
   // that time the core keeps the finished result and stalls the next request transaction.
   initial begin : rsp_side
      int hold;
      int taken;
      taken = 0;
      forever begin
         hold = burst ? 0 : $urandom_range(0, MAX_GAP);
         if (taken == 40 || taken == 400)
            hold = HOLD_CYC;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (reset || !rsp_valid)
            @(posedge clock);
         taken++;
      end
   end

   // This task offers one request transaction and returns at the edge that
   // accepts it. Valid stays high when the next transaction follows without a
   // gap, so valid never gets two assignments in one time step.
   task automatic send_req(input req_type item, input bit pinned, input rsp_type want);
      int gap;
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (item.mode == MODE_SEARCH)
         search_note_q.push_back('{pinned, want});
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // This task waits until every search has answered. Then it lets the requested
   // number of cycles pass, so that a load still in progress has finished.
   task automatic drain_idle(input int cycles);
      req_valid <= 1'b0;
      @(posedge clock);
      while (lookup_expect_q.size() != 0)
         @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid    <= 1'b0;
      layout_count = (value > DEPTH) ? DEPTH : int'(value);
   endtask

   function automatic void add_count(input logic [COUNT_W-1:0] value);
      row_t row;
      row.kind   = ROW_COUNT;
      row.count  = value;
      row.item   = '0;
      row.pinned = 1'b0;
      row.want   = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_load(input logic [SLOT_W-1:0] slot, input logic empty,
                                    input logic [KEY_IN_W-1:0] key);
      row_t row;
      row.kind            = ROW_ITEM;
      row.count           = '0;
      row.item.mode       = MODE_LOAD;
      row.item.slot_index = slot;
      row.item.slot_empty = empty;
      row.item.key_value  = key;
      row.pinned          = 1'b0;
      row.want            = '0;
      directed_rows.push_back(row);
   endfunction

   // The slot fields of a search are ignored, so they are set to all ones here.
   function automatic void add_search(input logic [KEY_IN_W-1:0] key, input bit pinned,
                                      input logic found, input logic [SLOT_W-1:0] pos);
      row_t row;
      row.kind          = ROW_ITEM;
      row.count         = '0;
      row.item.mode     = MODE_SEARCH;
      row.item.slot_index = '1;
      row.item.slot_empty = 1'b1;
      row.item.key_value  = key;
      row.pinned        = pinned;
      row.want.found    = found;
      row.want.position = pos;
      directed_rows.push_back(row);
   endfunction

   // This task runs one phase of random traffic. It writes the entry count and then
   // reloads the first span slots with an ascending run of keys, with some slots
   // marked empty. After that it mostly issues searches. A few loads mark slots
   // empty without breaking the order, and a few write random keys that break it.
   task automatic run_phase(input int unsigned count_value, input int span,
                            input int n_items, input int empty_pct);
      int              r;
      int              slot;
      longint unsigned acc;
      longint unsigned step_max;
      req_type         item;
      drain_idle(SETTLE_CYC);
      write_count(count_value[COUNT_W-1:0]);
      burst = ($urandom_range(0, 3) == 0);
      if (span > 0) begin
         step_max = 64'h1_0000_0000 / (span + 1) * 2;
         if (step_max > 64'hFFFF_FFFF)
            step_max = 64'hFFFF_FFFF;
         acc = 0;
         for (int i = 0; i < span; i++) begin
            // A zero step now and then puts equal keys side by side.
            if ($urandom_range(0, 7) != 0)
               acc += $urandom_range(1, step_max[31:0]);
            layout_gap[i] = ($urandom_range(0, 99) < empty_pct);
            // An empty slot keeps a stale key that the search must never look at.
            layout_key[i] = layout_gap[i] ? $urandom :
                            (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            item.mode       = MODE_LOAD;
            item.slot_index = i[SLOT_W-1:0];
            item.slot_empty = layout_gap[i];
            item.key_value  = layout_key[i];
            send_req(item, 1'b0, '0);
         end
      end
      for (int n = 0; n < n_items; n++) begin
         r               = $urandom_range(0, 19);
         slot            = (layout_count > 0) ? $urandom_range(0, layout_count - 1) : 0;
         item.slot_index = $urandom_range(0, DEPTH - 1);
         item.slot_empty = $urandom_range(0, 1);
         item.key_value  = $urandom;
         if (r == 0 || (r == 1 && layout_count == 0)) begin
            item.mode               = MODE_LOAD;
            layout_key[item.slot_index] = item.key_value;
            layout_gap[item.slot_index] = item.slot_empty;
         end else if (r == 1) begin
            item.mode        = MODE_LOAD;
            item.slot_index  = slot[SLOT_W-1:0];
            item.slot_empty  = 1'b1;
            item.key_value   = layout_key[slot];
            layout_gap[slot] = 1'b1;
         end else begin
            item.mode = MODE_SEARCH;
            r = $urandom_range(0, 9);
            if (r < 6 && layout_count > 0 && !layout_gap[slot])
               item.key_value = layout_key[slot];
            else if (r < 8 && layout_count > 0)
               item.key_value = layout_key[slot] + ((r % 2 == 1) ? 32'd1 : 32'hFFFF_FFFF);
            else if (r == 8)
               item.key_value = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
         end
         send_req(item, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      int c;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed table uses a small window of eight slots at the bottom of the
      // table. No slot above the window is read until the random part has loaded
      // the whole table.
      // After reset the entry count is zero, so any search misses.
      add_search(32'h0000_0000, 1'b1, 1'b0, 10'd0);
      // The empty string as a key is all zeros.
      add_load(10'd0, 1'b0, 32'h0000_0000);
      add_load(10'd1, 1'b1, 32'hFFFF_FFFF);
      add_load(10'd2, 1'b0, 32'h0000_0100);
      // The string "ABC" as a key is left-aligned and padded with zeros.
      add_load(10'd3, 1'b0, 32'h4142_4300);
      add_load(10'd4, 1'b1, 32'h0000_0000);
      add_load(10'd5, 1'b1, 32'h7FFF_FFFF);
      add_load(10'd6, 1'b0, 32'h8000_0000);
      add_load(10'd7, 1'b0, 32'hFFFF_FFFF);
      // The top slot is loaded now but lies outside every window searched here.
      add_load(10'd1023, 1'b0, 32'h1234_5678);
      add_count(11'd8);
      add_search(32'h4142_4300, 1'b1, 1'b1, 10'd3);
      add_search(32'h0000_0000, 1'b1, 1'b1, 10'd0);
      add_search(32'hFFFF_FFFF, 1'b1, 1'b1, 10'd7);
      // This search has to walk right past the empty slot 1.
      add_search(32'h0000_0100, 1'b0, 1'b0, 10'd0);
      add_search(32'h0000_0050, 1'b0, 1'b0, 10'd0);
      add_search(32'h8000_0000, 1'b0, 1'b0, 10'd0);
      // This search probes the empty slot 5, walks on to slot 6 and then narrows down to the
      // empty slot 4. No walk finds a key and the search stops.
      add_search(32'h5000_0000, 1'b0, 1'b0, 10'd0);
      add_count(11'd1);
      add_search(32'h0000_0000, 1'b1, 1'b1, 10'd0);
      add_search(32'hFFFF_FFFF, 1'b1, 1'b0, 10'd0);
      add_count(11'd2);
      add_search(32'h0000_0100, 1'b0, 1'b0, 10'd0);
      add_count(11'd3);
      add_search(32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0);
      add_count(11'd8);
      add_load(10'd4, 1'b0, 32'h5000_0000);
      add_search(32'h5000_0000, 1'b0, 1'b0, 10'd0);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_COUNT: begin
               drain_idle(SETTLE_CYC);
               write_count(directed_rows[i].count);
            end
            default: begin
               send_req(directed_rows[i].item, directed_rows[i].pinned,
                        directed_rows[i].want);
            end
         endcase
      end

      // The first phase fills the whole table under an entry count of all ones.
      // That count saturates to the table depth. Every later phase rewrites only a
      // prefix, so every slot stays loaded from here on.
      run_phase(2047, DEPTH, 50, 20);
      run_phase(1024, 0, 25, 0);
      run_phase(1023, 0, 15, 0);
      run_phase(0, 0, 10, 0);
      run_phase(1, 1, 15, 0);
      run_phase(2, 2, 15, 50);
      // In this phase every slot in the window starts out empty, so searches miss unless a random load has filled one.
      run_phase(48, 48, 15, 100);
      repeat (6) begin
         c = $urandom_range(3, 64);
         run_phase(c, c, 30, 30 * $urandom_range(0, 3));
      end

      drain_idle(DRAIN_CYC);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // This watchdog ends the run with a failure if it has not finished in time.
   initial begin : watchdog
      #(20_000_000);
      $display("tb: FAIL");
      $finish;
   end

endmodule

>>> sim.f
hdl/sstsrch_pkg.sv
hdl/sstsrch_engine.sv
hdl/sparse_sorted_table_search_core.sv
sim/tb.sv
